FILE: hdl/ipse_pkg.sv
// ----------------------------------------------------------------------------
// ipse_pkg
// Shared types and constants of the itemset prefix section encoder.
// ----------------------------------------------------------------------------
package ipse_pkg;

    localparam int LANES  = 4;
    localparam int PLANES = LANES - 1;
    localparam int IW     = 16;
    localparam int CW     = 17;

    typedef logic [IW-1:0] item_t;

    // per-lane compare outcome
    typedef struct packed {
        logic  match;
        item_t pref;
    } lane_res_t;

    // one result record as it leaves the block
    typedef struct packed {
        logic        overflow;
        logic        new_section;
        logic [15:0] itemset_index;
        logic [15:0] section_index;
        logic [31:0] support_count_out;
        item_t       suffix;
        item_t       prefix_2;
        item_t       prefix_1;
        item_t       prefix_0;
    } result_t;

endpackage

FILE: hdl/ipse_lane.sv
// ----------------------------------------------------------------------------
// ipse_lane
// One prefix lane: compares an item with the stored prefix item.
// ----------------------------------------------------------------------------
module ipse_lane
    import ipse_pkg::*;
(
    input  item_t     item,
    input  item_t     stored,
    input  logic      en,
    output lane_res_t res
);

    // lanes beyond the prefix length always match and report zero
    assign res.match = !en || (item == stored);
    assign res.pref  = en ? item : '0;

endmodule

FILE: hdl/ipse_merge.sv
// ----------------------------------------------------------------------------
// ipse_merge
// Combines the lane compares into the section decision and the result record.
// ----------------------------------------------------------------------------
module ipse_merge
    import ipse_pkg::*;
(
    input  lane_res_t [PLANES-1:0] lanes,
    input  logic                   have_prefix,
    input  logic                   full,
    input  item_t                  suffix,
    input  logic [31:0]            support_count,
    input  logic [CW-1:0]          section_count,
    input  logic [CW-1:0]          itemset_count,
    output logic                   fresh,
    output result_t                res
);

    logic          all_match;
    logic [CW-1:0] sec;

    always_comb
    begin
        all_match = 1'b1;
        for (int i = 0; i < PLANES; i++)
        begin
            all_match = all_match & lanes[i].match;
        end
        fresh = !have_prefix || !all_match;
        sec   = fresh ? section_count : section_count - CW'(1);

        res = '0;
        if (full)
        begin
            res.overflow = 1'b1;
        end
        else
        begin
            res.new_section       = fresh;
            res.prefix_0          = lanes[0].pref;
            res.prefix_1          = lanes[1].pref;
            res.prefix_2          = lanes[2].pref;
            res.suffix            = suffix;
            res.support_count_out = support_count;
            res.section_index     = sec[15:0];
            res.itemset_index     = itemset_count[15:0];
        end
    end

endmodule

FILE: hdl/ipse_skid.sv
// ----------------------------------------------------------------------------
// ipse_skid
// Output register with a skid stage so input accepts while a result waits.
// ----------------------------------------------------------------------------
module ipse_skid
    import ipse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (push && (pop || !out_valid_reg))
        begin
            out_data_reg <= in_data;
        end
        if (push && out_valid_reg && !pop)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

FILE: hdl/itemset_prefix_section_encoder.sv
// ----------------------------------------------------------------------------
// itemset_prefix_section_encoder
// Front codes sorted itemsets into sections that share a common prefix.
// ----------------------------------------------------------------------------
// output: each result is registered, in the skid stage while the output stage waits
// throughput: one itemset per cycle when not stalled; prefix lanes compare in parallel
//   and the section counters update in the same cycle, a skid stage holds one result
// reset: rst_n clears counters, the stored prefix and both output stages;
//   itemset_len returns to 2
module itemset_prefix_section_encoder
    import ipse_pkg::*;
#(
    parameter int MAX_K      = 4,
    parameter int ITEM_WIDTH = 16,
    parameter int CAPACITY   = 65536
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_data,     // itemset_len
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,      // item_0, item_1, item_2, item_3, support_count
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,      // prefix_0, prefix_1, prefix_2, suffix,
                                       // support_count_out, section_index, itemset_index
    output logic [1:0]   m_tuser       // new_section, overflow
);

    localparam int          LIM_I    = (MAX_K < LANES) ? MAX_K : LANES;
    localparam logic [2:0]  LIM      = 3'(LIM_I);
    localparam logic [IW-1:0] ITEM_MASK =
        (ITEM_WIDTH >= IW) ? {IW{1'b1}} : IW'((32'd1 << ITEM_WIDTH) - 32'd1);
    localparam logic [24:0] CAP      = 25'(CAPACITY);

    logic [2:0]              itemset_len_reg;
    logic                    have_prefix_reg;
    item_t [PLANES-1:0]      last_prefix_reg;
    logic [CW-1:0]           section_count_reg;
    logic [CW-1:0]           itemset_count_reg;

    item_t [LANES-1:0]       items;
    logic [2:0]              k;
    logic [2:0]              p;
    logic [1:0]              suffix_sel;
    logic [PLANES-1:0]       lane_en;
    lane_res_t [PLANES-1:0]  lanes;
    logic                    full;
    logic                    fresh;
    logic                    accept;
    result_t                 res;
    result_t                 res_out;

    assign cfg_ready = 1'b1;

    // effective itemset length, clamped to MAX_K and the lane count, zero read as one
    always_comb
    begin
        if (itemset_len_reg == 3'd0)
        begin
            k = 3'd1;
        end
        else if (itemset_len_reg > LIM)
        begin
            k = LIM;
        end
        else
        begin
            k = itemset_len_reg;
        end
        p          = k - 3'd1;
        suffix_sel = p[1:0];
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            items[i] = s_tdata[i*IW +: IW] & ITEM_MASK;
        end
        for (int i = 0; i < PLANES; i++)
        begin
            lane_en[i] = 3'(i) < p;
        end
    end

    genvar g;
    generate
        for (g = 0; g < PLANES; g++)
        begin : g_lane
            ipse_lane u_lane (
                .item   (items[g]),
                .stored (last_prefix_reg[g]),
                .en     (lane_en[g]),
                .res    (lanes[g])
            );
        end
    endgenerate

    assign full = {8'd0, itemset_count_reg} >= CAP;

    ipse_merge u_merge (
        .lanes         (lanes),
        .have_prefix   (have_prefix_reg),
        .full          (full),
        .suffix        (items[suffix_sel]),
        .support_count (s_tdata[95:64]),
        .section_count (section_count_reg),
        .itemset_count (itemset_count_reg),
        .fresh         (fresh),
        .res           (res)
    );

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itemset_len_reg   <= 3'd2;
            have_prefix_reg   <= 1'b0;
            last_prefix_reg   <= '0;
            section_count_reg <= '0;
            itemset_count_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                itemset_len_reg <= cfg_data;
            end
            if (accept && !full)
            begin
                itemset_count_reg <= itemset_count_reg + CW'(1);
                if (fresh)
                begin
                    have_prefix_reg   <= 1'b1;
                    section_count_reg <= section_count_reg + CW'(1);
                    for (int i = 0; i < PLANES; i++)
                    begin
                        last_prefix_reg[i] <= lanes[i].pref;
                    end
                end
            end
        end
    end

    ipse_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out)
    );

    assign m_tdata = {res_out.itemset_index, res_out.section_index,
                      res_out.support_count_out, res_out.suffix,
                      res_out.prefix_2, res_out.prefix_1, res_out.prefix_0};
    assign m_tuser = {res_out.overflow, res_out.new_section};

    // input stalls only while both output stages hold a result
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_prefix_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> have_prefix_reg)
        else $error("no stored prefix after an accepted itemset");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !full) |=> itemset_count_reg == $past(itemset_count_reg) + CW'(1))
        else $error("itemset count did not advance by one");

    a_overflow_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> !m_tuser[0])
        else $error("dropped itemset reported as new section");

endmodule
